// ===== rtl/pce_pkg.sv =====
// ----------------------------------------------------------------------------
// pce_pkg
// Shared codes, types and limits of the piecewise Chebyshev evaluator.
// ----------------------------------------------------------------------------
package pce_pkg;

  localparam int ValW     = 32;
  localparam int IdxMaxW  = 10;  // interval index, enough for 1024 intervals
  localparam int OrdMaxW  = 6;   // series order, enough for degree 63

  // store sizes, tied to the register and result field widths
  localparam int MAX_INTERVALS = 64;
  localparam int MAX_ORDER     = 31;

  localparam logic [1:0] OP_LOAD_BP   = 2'd0;
  localparam logic [1:0] OP_LOAD_COEF = 2'd1;
  localparam logic [1:0] OP_EVAL      = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic CFG_INTERVAL_COUNT = 1'b0;
  localparam logic CFG_SERIES_ORDER   = 1'b1;

  typedef struct packed {
    logic                      start;
    logic signed [ValW-1:0]    t;
    logic [IdxMaxW-1:0]        interval;
    logic [OrdMaxW-1:0]        order;
  } ser_cmd_t;

  typedef struct packed {
    logic                      done;
    logic signed [ValW-1:0]    value;
    logic                      sat;
  } ser_res_t;

endpackage

// ===== rtl/piecewise_chebyshev_eval_top.sv =====
// ----------------------------------------------------------------------------
// piecewise_chebyshev_eval_top
// Piecewise Chebyshev series evaluator with breakpoint and coefficient memories.
// ----------------------------------------------------------------------------
// Load items give no result. An evaluate item scans the breakpoint memory
// one entry a cycle, maps the point onto [-1,1] by a bit-serial divider,
// and sums the series on one multiply-accumulate unit fed by the coefficient
// memory, each degree passing through a multiply state and an accumulate
// state. One item is worked on at a time; a finished result waits in the
// output register while the next item is taken. Both memories need no
// clearing after reset, so the block takes items straight away.
module piecewise_chebyshev_eval_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [6:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [6:0]         slot_i,
  input  logic [4:0]         term_i,
  input  logic signed [31:0] operand_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] approx_value_o,
  output logic [5:0]         chosen_interval_o,
  output logic [1:0]         status_o
);
  import pce_pkg::*;

  localparam int BAW = $clog2(MAX_INTERVALS + 1);
  localparam int FW  = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CAW = $clog2(MAX_INTERVALS * (MAX_ORDER + 1));

  typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_DIVIDE, S_SERIES, S_RESULT} state_e;

  logic [6:0] icount_q;
  logic [4:0] sorder_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icount_q <= 7'd1;
      sorder_q <= 5'd20;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_INTERVAL_COUNT: icount_q <= cfg_data_i;
        CFG_SERIES_ORDER:   sorder_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // breakpoint memory
  logic signed [31:0] bp_mem [MAX_INTERVALS + 1];
  logic signed [31:0] bp_rd_q;
  logic [BAW-1:0]     bp_raddr;
  logic               bp_we;

  state_e             state_q;
  logic [BAW-1:0]     j_q, cnt_q;
  logic [OrdMaxW-1:0] ord_q;
  logic signed [31:0] x_q, prev_q, a_q, b_q;
  logic [FW-1:0]      found_q;
  logic               found_v_q;
  logic               div_start_q, ser_start_q;
  logic               out_valid_q;
  logic signed [31:0] out_val_q;
  logic [5:0]         out_int_q;
  logic [1:0]         out_st_q;
  logic signed [31:0] res_val_q;
  logic [1:0]         res_st_q;

  assign bp_we    = in_acc && (op_i == OP_LOAD_BP) && (int'(slot_i) <= MAX_INTERVALS);
  assign bp_raddr = (state_q == S_SEARCH && j_q != cnt_q) ? j_q + BAW'(1) : '0;

  always_ff @(posedge clk_i) begin
    if (bp_we) begin
      bp_mem[BAW'(slot_i)] <= operand_i;
    end
    bp_rd_q <= bp_mem[bp_raddr];
  end

  // coefficient writes go to the series unit
  logic               cw_en;
  logic [CAW-1:0]     cw_addr;
  assign cw_en   = in_acc && (op_i == OP_LOAD_COEF) && (int'(slot_i) < MAX_INTERVALS)
                   && (int'(term_i) <= MAX_ORDER);
  assign cw_addr = CAW'(int'(slot_i) * (MAX_ORDER + 1) + int'(term_i));

  logic               div_done;
  logic signed [31:0] div_quot;
  ser_cmd_t           ser_cmd;
  ser_res_t           ser_res;

  pce_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .x_i     (x_q),
    .a_i     (a_q),
    .b_i     (b_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign ser_cmd.start    = ser_start_q;
  assign ser_cmd.t        = div_quot;
  assign ser_cmd.interval = IdxMaxW'(found_q);
  assign ser_cmd.order    = ord_q;

  pce_series u_series (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (ser_cmd),
    .cw_en_i   (cw_en),
    .cw_addr_i (cw_addr),
    .cw_data_i (operand_i),
    .res_o     (ser_res)
  );

  // interval j_q-1 spans prev_q .. bp_rd_q in the search
  logic hit;
  assign hit = (j_q != '0) && (bp_rd_q > prev_q) && (x_q >= prev_q) && (x_q <= bp_rd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      found_v_q   <= 1'b0;
      div_start_q <= 1'b0;
      ser_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      ser_start_q <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && op_i == OP_EVAL) begin
            x_q       <= operand_i;
            found_q   <= '0;
            found_v_q <= 1'b0;
            j_q       <= '0;
            cnt_q     <= (int'(icount_q) > MAX_INTERVALS) ? BAW'(MAX_INTERVALS)
                                                          : BAW'(icount_q);
            ord_q     <= (int'(sorder_q) > MAX_ORDER) ? OrdMaxW'(MAX_ORDER)
                                                      : OrdMaxW'(sorder_q);
            if (icount_q == '0) begin
              res_val_q <= '0;
              res_st_q  <= ST_RANGE;
              state_q   <= S_RESULT;
            end else begin
              state_q <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          prev_q <= bp_rd_q;
          j_q    <= j_q + BAW'(1);
          if (hit) begin
            found_q   <= FW'(j_q - BAW'(1));
            found_v_q <= 1'b1;
            a_q       <= prev_q;
            b_q       <= bp_rd_q;
          end
          if (j_q == cnt_q) begin
            if (hit || found_v_q) begin
              div_start_q <= 1'b1;
              state_q     <= S_DIVIDE;
            end else begin
              res_val_q <= '0;
              res_st_q  <= ST_RANGE;
              state_q   <= S_RESULT;
            end
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            ser_start_q <= 1'b1;
            state_q     <= S_SERIES;
          end
        end
        S_SERIES: begin
          if (ser_res.done) begin
            res_val_q <= ser_res.value;
            res_st_q  <= ser_res.sat ? ST_SAT : ST_OK;
            state_q   <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_val_q   <= res_val_q;
            out_int_q   <= found_v_q ? 6'(found_q) : 6'd0;
            out_st_q    <= res_st_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign approx_value_o    = out_val_q;
  assign chosen_interval_o = out_int_q;
  assign status_o          = out_st_q;

  a_div_done_in_divide : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIVIDE)
    else $error("divider finished outside the divide phase");

  a_ser_done_in_series : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_res.done |-> state_q == S_SERIES)
    else $error("series unit finished outside the series phase");

  a_out_from_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_RESULT)
    else $error("result shown without an evaluation finishing");

  a_found_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_v_q && state_q != S_IDLE) |-> int'(found_q) < int'(cnt_q))
    else $error("chosen interval beyond the interval count");

endmodule

// ===== rtl/pce_divider.sv =====
// ----------------------------------------------------------------------------
// pce_divider
// Maps x onto t in [-1,1] (Q1.30) by a restoring divide, one bit a cycle.
// ----------------------------------------------------------------------------
module pce_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               done_o,
  output logic signed [31:0] quot_o
);
  import pce_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_PREP, D_RUN} dstate_e;

  dstate_e           state_q;
  logic [31:0]       mag_q, d_q, rem_q;
  logic              neg_q, done_q;
  logic [30:0]       low_q, quo_q;
  logic [4:0]        cnt_q;

  logic signed [33:0] num;
  logic signed [32:0] dif;
  logic [62:0]        dividend;
  logic [32:0]        trial;
  logic               ge;

  assign num      = (34'(x_i) <<< 1) - 34'(a_i) - 34'(b_i);
  assign dif      = 33'(b_i) - 33'(a_i);
  assign dividend = {1'b0, mag_q, 30'b0} + 63'(d_q >> 1);
  assign trial    = {rem_q, low_q[30]};
  assign ge       = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (start_i) begin
            // |2x-a-b| never exceeds b-a, so it fits in 32 bits
            mag_q   <= num[33] ? 32'(-num) : 32'(num);
            neg_q   <= num[33];
            d_q     <= 32'(dif);
            state_q <= D_PREP;
          end
        end
        D_PREP: begin
          // quotient is at most 2^30, so the top bits start below d
          rem_q   <= dividend[62:31];
          low_q   <= dividend[30:0];
          quo_q   <= '0;
          cnt_q   <= 5'd30;
          state_q <= D_RUN;
        end
        D_RUN: begin
          rem_q <= ge ? 32'(trial - {1'b0, d_q}) : trial[31:0];
          low_q <= {low_q[29:0], 1'b0};
          quo_q <= {quo_q[29:0], ge};
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == '0) begin
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

// ===== rtl/pce_series.sv =====
// ----------------------------------------------------------------------------
// pce_series
// Coefficient memory and the T_n recurrence with multiply-accumulate.
// ----------------------------------------------------------------------------
module pce_series (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pce_pkg::ser_cmd_t         cmd_i,
  input  logic                      cw_en_i,
  input  logic [$clog2(pce_pkg::MAX_INTERVALS*(pce_pkg::MAX_ORDER+1))-1:0] cw_addr_i,
  input  logic signed [31:0]        cw_data_i,
  output pce_pkg::ser_res_t         res_o
);
  import pce_pkg::*;

  localparam int Depth = MAX_INTERVALS * (MAX_ORDER + 1);
  localparam int CAW   = $clog2(Depth);
  localparam int OW    = $clog2(MAX_ORDER + 1);
  localparam int AccW  = 48;

  typedef enum logic [2:0] {C_IDLE, C_C0, C_MUL, C_ACC, C_FIN} cstate_e;

  logic signed [31:0] coef_mem [Depth];
  logic signed [31:0] c_rd_q;
  logic [CAW-1:0]     raddr, caddr_q;

  cstate_e            state_q;
  logic signed [31:0] t_q, tcur_q, tprev_q;
  logic [OW-1:0]      n_q, ord_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [63:0] pc_q, pt_q;
  ser_res_t           res_q;

  logic signed [63:0] mul_c, mul_t, pc_rnd, pt_rnd;
  logic signed [63:0] pc_sh, pt_sh;
  logic signed [35:0] t_next;
  logic signed [AccW-1:0] acc_rnd, acc_sh;
  logic [CAW-1:0]     base;

  assign base  = CAW'(int'(cmd_i.interval) * (MAX_ORDER + 1));
  assign raddr = (state_q == C_IDLE) ? base : caddr_q;

  always_ff @(posedge clk_i) begin
    if (cw_en_i) begin
      coef_mem[cw_addr_i] <= cw_data_i;
    end
    c_rd_q <= coef_mem[raddr];
  end

  assign mul_c   = c_rd_q * tcur_q;
  assign mul_t   = t_q * tcur_q;
  // round half away from zero: add half, less one when negative, then shift
  assign pc_rnd  = pc_q + (pc_q[63] ? 64'sd524287 : 64'sd524288);
  assign pt_rnd  = pt_q + (pt_q[63] ? 64'sd268435455 : 64'sd268435456);
  assign pc_sh   = pc_rnd >>> 20;
  assign pt_sh   = pt_rnd >>> 29;
  assign t_next  = 36'(pt_sh) - 36'(tprev_q);
  assign acc_rnd = acc_q + (acc_q[AccW-1] ? 48'sd511 : 48'sd512);
  assign acc_sh  = acc_rnd >>> 10;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= C_IDLE;
      res_q.done <= 1'b0;
    end else begin
      res_q.done <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (cmd_i.start) begin
            t_q     <= cmd_i.t;
            tcur_q  <= cmd_i.t;
            tprev_q <= 32'sd1073741824;
            ord_q   <= OW'(cmd_i.order);
            n_q     <= OW'(1);
            caddr_q <= base + CAW'(1);
            state_q <= C_C0;
          end
        end
        C_C0: begin
          // c0 is halved: c0 * 2^29 scaled down to Q.10 like the other terms
          acc_q <= AccW'(c_rd_q) <<< 9;
          if (ord_q == '0) begin
            state_q <= C_FIN;
          end else begin
            state_q <= C_MUL;
          end
        end
        C_MUL: begin
          pc_q    <= mul_c;
          pt_q    <= mul_t;
          // next coefficient is read during the accumulate cycle
          caddr_q <= caddr_q + CAW'(1);
          state_q <= C_ACC;
        end
        C_ACC: begin
          acc_q   <= acc_q + AccW'(pc_sh);
          tprev_q <= tcur_q;
          tcur_q  <= 32'(t_next);
          if (n_q == ord_q) begin
            state_q <= C_FIN;
          end else begin
            n_q     <= n_q + OW'(1);
            state_q <= C_MUL;
          end
        end
        C_FIN: begin
          res_q.done <= 1'b1;
          if (acc_sh > 48'sd2147483647) begin
            res_q.value <= 32'sh7fffffff;
            res_q.sat   <= 1'b1;
          end else if (acc_sh < -48'sd2147483648) begin
            res_q.value <= 32'sh80000000;
            res_q.sat   <= 1'b1;
          end else begin
            res_q.value <= 32'(acc_sh);
            res_q.sat   <= 1'b0;
          end
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign res_o = res_q;

endmodule

// ===== tb/piecewise_chebyshev_eval_top_test.sv =====
// ----------------------------------------------------------------------------
// piecewise_chebyshev_eval_top_test
// Fills both stores, then sends directed and random load and evaluate items
// under several interval and order settings. Random gaps and stalls are used
// on both channels. Every result is checked against a bit-exact prediction.
// ----------------------------------------------------------------------------
module piecewise_chebyshev_eval_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pce_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int NumSlots = 64;
  localparam int TermsPerSlot = 32;
  localparam int SettleCycles = 250;
  // low degrees are filled on every interval, all degrees on the first few
  localparam int LowTerms = 4;
  localparam int FullSlots = 8;

  typedef struct {
    logic [1:0]         op;
    logic [6:0]         slot;
    logic [4:0]         term;
    logic signed [31:0] operand;
  } work_item_t;

  typedef struct {
    logic signed [31:0] value;
    logic [5:0]         interval;
    logic [1:0]         status;
  } eval_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [0:0]         cfg_index_i = '0;
  logic [6:0]         cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         op_i = '0;
  logic [6:0]         slot_i = '0;
  logic [4:0]         term_i = '0;
  logic signed [31:0] operand_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] approx_value_o;
  logic [5:0]         chosen_interval_o;
  logic [1:0]         status_o;

  piecewise_chebyshev_eval_top uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predicted block state
  logic signed [31:0] bp_mem [0:NumSlots];
  logic signed [31:0] coef_mem [0:NumSlots*TermsPerSlot-1];
  int unsigned        cur_count = 1;
  int unsigned        cur_order = 20;
  // breakpoints as they will stand once every pending item is in
  logic signed [31:0] planned_bp [0:NumSlots];

  work_item_t   pending_items[$];
  eval_result_t expected_results[$];
  int           errors = 0;
  bit           calm = 1'b0;
  int           send_gap = 0;
  int           recv_gap = 0;
  work_item_t   next_item;

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint round_away(longint v, int s);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic eval_result_t series_at(logic signed [31:0] x);
    int           cnt, found, base;
    longint       a, b, d, num, t, tprev, tcur, nxt, acc, val;
    longint unsigned mag, q;
    eval_result_t r;
    cnt = (cur_count > NumSlots) ? NumSlots : cur_count;
    found = -1;
    for (int i = 0; i < cnt; i++) begin
      a = bp_mem[i];
      b = bp_mem[i+1];
      if (b > a && x >= a && x <= b) found = i;
    end
    if (found < 0) begin
      r.value = '0;
      r.interval = '0;
      r.status = ST_RANGE;
      return r;
    end
    a = bp_mem[found];
    b = bp_mem[found+1];
    d = b - a;
    num = 2 * longint'(x) - a - b;
    mag = (num < 0) ? longint'(-num) : num;
    q = ((mag << 30) + (longint'(d) >> 1)) / longint'(d);
    t = (num < 0) ? -longint'(q) : longint'(q);
    base = found * TermsPerSlot;
    acc = round_away(longint'(coef_mem[base]) * (64'sd1 << 29), 20);
    tprev = 64'sd1 << 30;
    tcur = t;
    for (int n = 1; n <= cur_order; n++) begin
      acc += round_away(longint'(coef_mem[base+n]) * tcur, 20);
      nxt = round_away(t * tcur, 29) - tprev;
      tprev = tcur;
      tcur = nxt;
    end
    val = round_away(acc, 10);
    r.status = ST_OK;
    if (val > 64'sd2147483647) begin
      val = 64'sd2147483647;
      r.status = ST_SAT;
    end else if (val < -64'sd2147483648) begin
      val = -64'sd2147483648;
      r.status = ST_SAT;
    end
    r.value = val[31:0];
    r.interval = found[5:0];
    return r;
  endfunction

  task automatic take_item(work_item_t it);
    case (it.op)
      OP_LOAD_BP: begin
        if (it.slot <= NumSlots) bp_mem[it.slot] = it.operand;
      end
      OP_LOAD_COEF: begin
        if (it.slot < NumSlots) coef_mem[it.slot*TermsPerSlot + it.term] = it.operand;
      end
      OP_EVAL: expected_results.push_back(series_at(it.operand));
      default: ;
    endcase
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        next_item.op = op_i;
        next_item.slot = slot_i;
        next_item.term = term_i;
        next_item.operand = operand_i;
        take_item(next_item);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          next_item = pending_items.pop_front();
          op_i <= next_item.op;
          slot_i <= next_item.slot;
          term_i <= next_item.term;
          operand_i <= next_item.operand;
          in_valid_i <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    eval_result_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected item value %h interval %0d status %0d",
                   $realtime, approx_value_o, chosen_interval_o, status_o);
        end else begin
          e = expected_results.pop_front();
          if (approx_value_o !== e.value) begin
            errors++;
            $display("%0t: value expected %h actual %h", $realtime, e.value, approx_value_o);
          end
          if (chosen_interval_o !== e.interval) begin
            errors++;
            $display("%0t: interval expected %0d actual %0d", $realtime, e.interval,
                     chosen_interval_o);
          end
          if (status_o !== e.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $realtime, e.status, status_o);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        recv_gap <= pick_gap();
      end
    end
  end

  task automatic push(logic [1:0] op, logic [6:0] slot, logic [4:0] term,
                      logic signed [31:0] operand);
    work_item_t it;
    it.op = op;
    it.slot = slot;
    it.term = term;
    it.operand = operand;
    if (op == OP_LOAD_BP && slot <= NumSlots) planned_bp[slot] = operand;
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [6:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_INTERVAL_COUNT) cur_count = data;
    else cur_order = data[4:0];
  endtask

  function automatic logic signed [31:0] rand_coef();
    if ($urandom_range(0, 9) < 8) return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
    return $urandom;
  endfunction

  // mode 0 spans the whole range, 1 is narrow with zero-width intervals, 2 is unordered
  task automatic load_layout(int mode);
    longint acc;
    acc = (mode == 0) ? -64'sd2147483648 : $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
    for (int i = 0; i <= NumSlots; i++) begin
      if (mode == 2) push(OP_LOAD_BP, 7'(i), 5'($urandom), $urandom);
      else if (mode == 0 && i == NumSlots) push(OP_LOAD_BP, 7'(i), 5'($urandom), 32'sh7FFF_FFFF);
      else begin
        push(OP_LOAD_BP, 7'(i), 5'($urandom), acc[31:0]);
        if (mode == 0) acc += $urandom_range(0, 32'h03FF_FFFF);
        else if ($urandom_range(0, 99) < 15) acc += 0;
        else acc += $urandom_range(1, 32'h0010_0000);
      end
    end
  endtask

  function automatic logic signed [31:0] pick_point();
    int r, top;
    longint lo, span;
    top = (cur_count > NumSlots) ? NumSlots : cur_count;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom;
    if (r < 30) return planned_bp[$urandom_range(0, top)];
    lo = planned_bp[0];
    span = longint'(planned_bp[top]) - lo;
    if (span <= 0) return planned_bp[0];
    return 32'(lo + ({$urandom, $urandom} % (span + 1)));
  endfunction

  task automatic random_phase(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 70) push(OP_EVAL, 7'($urandom), 5'($urandom), pick_point());
      else if (r < 90)
        push(OP_LOAD_COEF, 7'($urandom_range(0, NumSlots-1)), 5'($urandom), rand_coef());
      else if (r < 93)
        push(OP_LOAD_BP, 7'($urandom_range(0, NumSlots)), 5'($urandom), $urandom);
      else if (r < 96) push(OpUnused, 7'($urandom), 5'($urandom), $urandom);
      else push(2'($urandom_range(0, 1)), 7'($urandom_range(NumSlots, 127)), 5'($urandom),
                $urandom);
    end
  endtask

  initial begin
    // orders above LowTerms-1 only go with counts up to FullSlots
    int counts[8] = '{8, 1, 0, 127, 5, 33, 64, 2};
    int orders[8] = '{31, 20, 0, 3, 1, 3, 0, 15};
    int rc;
    for (int i = 0; i <= NumSlots; i++) begin
      bp_mem[i] = '0;
      planned_bp[i] = '0;
    end
    for (int i = 0; i < NumSlots*TermsPerSlot; i++) coef_mem[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_cfg(CFG_INTERVAL_COUNT, 7'd64);
    write_cfg(CFG_SERIES_ORDER, 7'(LowTerms - 1));

    // every entry that can be read is written before anything is read
    load_layout(0);
    for (int s = 0; s < NumSlots; s++)
      for (int n = 0; n < TermsPerSlot; n++)
        if (n < LowTerms || s < FullSlots) push(OP_LOAD_COEF, 7'(s), 5'(n), rand_coef());
    wait_idle();

    // field extremes, shared boundaries, ignored loads and the unused op
    push(OP_EVAL, 7'd0, 5'd0, 32'sh8000_0000);
    push(OP_EVAL, 7'd127, 5'd31, 32'sh7FFF_FFFF);
    push(OP_EVAL, 7'd5, 5'd3, planned_bp[10]);
    push(OP_EVAL, 7'd0, 5'd0, 32'sd0);
    push(OP_LOAD_COEF, 7'd63, 5'd31, 32'sh7FFF_FFFF);
    push(OP_LOAD_COEF, 7'd63, 5'd0, 32'sh8000_0000);
    push(OP_EVAL, 7'd0, 5'd0, planned_bp[63]);
    push(OP_EVAL, 7'd0, 5'd0, planned_bp[64] - 1);
    push(OP_LOAD_COEF, 7'd64, 5'd0, 32'sd1);
    push(OP_LOAD_COEF, 7'd127, 5'd31, 32'sd1);
    push(OP_LOAD_BP, 7'd65, 5'd0, 32'sd0);
    push(OP_LOAD_BP, 7'd127, 5'd31, 32'shFFFF_FFFF);
    push(OpUnused, 7'd127, 5'd31, 32'shFFFF_FFFF);
    push(OpUnused, 7'd0, 5'd0, 32'sd0);
    push(OP_EVAL, 7'd0, 5'd0, planned_bp[0]);
    wait_idle();

    // zero-width and unordered intervals
    load_layout(1);
    push(OP_EVAL, 7'd0, 5'd0, planned_bp[1]);
    push(OP_EVAL, 7'd0, 5'd0, planned_bp[0] - 1);
    push(OP_EVAL, 7'd0, 5'd0, planned_bp[64] + 1);
    load_layout(2);
    push(OP_EVAL, 7'd0, 5'd0, planned_bp[30]);
    push(OP_EVAL, 7'd0, 5'd0, $urandom);
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      calm = (ph % 4 == 3);
      if (ph < 8) begin
        write_cfg(CFG_INTERVAL_COUNT, 7'(counts[ph]));
        write_cfg(CFG_SERIES_ORDER, 7'(orders[ph]));
      end else begin
        rc = $urandom_range(0, 127);
        write_cfg(CFG_INTERVAL_COUNT, 7'(rc));
        if (rc > FullSlots) write_cfg(CFG_SERIES_ORDER, 7'($urandom_range(0, LowTerms-1)));
        else write_cfg(CFG_SERIES_ORDER, 7'($urandom_range(0, 31)));
      end
      if (ph % 2 == 0) load_layout((ph % 3 == 1) ? 1 : 0);
      random_phase(20);
      wait_idle();
      random_phase(20);
      wait_idle();
    end

    if (errors == 0) $display("piecewise_chebyshev_eval_top test passed");
    else $display("piecewise_chebyshev_eval_top test failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("piecewise_chebyshev_eval_top test failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pce_pkg.sv
rtl/pce_divider.sv
rtl/pce_series.sv
rtl/piecewise_chebyshev_eval_top.sv
tb/piecewise_chebyshev_eval_top_test.sv
